/* hw/rtl/dsw_pkg.sv */
// Shared types and fixed field widths of the dice sum way counter.
package dsw_pkg;

    // Widths of the transaction fields on the ports.
    localparam int DICE_COUNT_W = 7;
    localparam int FACE_COUNT_W = 7;
    localparam int TARGET_SUM_W = 11;
    localparam int WAY_COUNT_W  = 64;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_DRAIN,
        ST_HOLD,
        ST_FETCH,
        ST_RESULT
    } dsw_state_t;

    // Control that travels with every read issued to the row stores.
    typedef struct packed {
        logic valid;      // A read is issued this cycle.
        logic clear;      // A new query starts; clears the saturation flag.
        logic fetch;      // Final read of the answer, not a row update.
        logic first_row;  // Previous row is the virtual start row, not a store.
        logic sub_valid;  // The entry leaving the window exists.
        logic init_a;     // Start-row value of the entry entering the window.
        logic init_b;     // Start-row value of the entry leaving the window.
        logic wr_bank;    // Store that receives the new row.
        logic rd_bank;    // Store that holds the previous row.
    } dsw_ctrl_t;

endpackage

/* hw/rtl/dsw_row_mem.sv */
// One row store: synchronous memory with one write port and two read ports.
module dsw_row_mem
    import dsw_pkg::*;
#(
    parameter int DEPTH  = 1025,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 64
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* hw/rtl/dsw_window.sv */
// Sliding window datapath: reads the previous row, updates the window sum, writes the new row.
module dsw_window
    import dsw_pkg::*;
#(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_FACES  = 64,
    parameter int COUNT_BITS = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  dsw_ctrl_t                       ctrl,
    input  logic [$clog2(MAX_TARGET+1)-1:0] issue_idx,
    input  logic [COUNT_BITS-1:0]           rd0_a,
    input  logic [COUNT_BITS-1:0]           rd0_b,
    input  logic [COUNT_BITS-1:0]           rd1_a,
    input  logic [COUNT_BITS-1:0]           rd1_b,
    output logic                            we0,
    output logic                            we1,
    output logic [$clog2(MAX_TARGET+1)-1:0] waddr,
    output logic [COUNT_BITS-1:0]           wdata,
    output logic [COUNT_BITS-1:0]           result_value,
    output logic                            sat_seen
);

    localparam int ADDR_W = $clog2(MAX_TARGET + 1);
    localparam int FACE_W = $clog2(MAX_FACES + 1);
    localparam int SUM_W  = COUNT_BITS + FACE_W;
    localparam logic [SUM_W-1:0] LIMIT = {{FACE_W{1'b0}}, {COUNT_BITS{1'b1}}};

    dsw_ctrl_t                 s2_ctrl_reg;
    logic [ADDR_W-1:0]         s2_idx_reg;
    logic                      s3_valid_reg;
    logic                      s3_valid_next;
    logic                      s3_bank_reg;
    logic [ADDR_W-1:0]         s3_idx_reg;
    logic signed [COUNT_BITS:0] s3_delta_reg;
    logic signed [COUNT_BITS:0] s3_delta_next;
    logic [SUM_W-1:0]          win_reg;
    logic [SUM_W-1:0]          win_next;
    logic                      sat_reg;
    logic                      sat_next;
    logic [COUNT_BITS-1:0]     a_val;
    logic [COUNT_BITS-1:0]     b_val;
    logic [SUM_W-1:0]          sum;

    // Stage two: pick the entering and leaving entries and form their difference.
    always_comb
    begin
        if (s2_ctrl_reg.first_row)
        begin
            a_val = COUNT_BITS'(s2_ctrl_reg.init_a);
            b_val = COUNT_BITS'(s2_ctrl_reg.init_b);
        end
        else
        begin
            a_val = s2_ctrl_reg.rd_bank ? rd1_a : rd0_a;
            b_val = s2_ctrl_reg.rd_bank ? rd1_b : rd0_b;
        end
        if (!s2_ctrl_reg.sub_valid)
        begin
            b_val = '0;
        end
        s3_delta_next = $signed({1'b0, a_val}) - $signed({1'b0, b_val});
        s3_valid_next = s2_ctrl_reg.valid && !s2_ctrl_reg.fetch;
    end

    assign result_value = a_val;

    // Stage three: exact window sum, saturated copy written to the new row.
    always_comb
    begin
        sum      = win_reg + SUM_W'(s3_delta_reg);
        win_next = win_reg;
        sat_next = sat_reg;
        wdata    = '0;
        if (s3_valid_reg)
        begin
            if (s3_idx_reg == '0)
            begin
                win_next = '0;
            end
            else
            begin
                win_next = sum;
                if (sum >= LIMIT)
                begin
                    wdata    = LIMIT[COUNT_BITS-1:0];
                    sat_next = 1'b1;
                end
                else
                begin
                    wdata = sum[COUNT_BITS-1:0];
                end
            end
        end
        if (ctrl.clear)
        begin
            sat_next = 1'b0;
        end
    end

    assign we0      = s3_valid_reg && !s3_bank_reg;
    assign we1      = s3_valid_reg && s3_bank_reg;
    assign waddr    = s3_idx_reg;
    assign sat_seen = sat_reg;

    // Control registers of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_ctrl_reg  <= '0;
            s3_valid_reg <= 1'b0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            s2_ctrl_reg  <= ctrl;
            s3_valid_reg <= s3_valid_next;
            sat_reg      <= sat_next;
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        s2_idx_reg   <= issue_idx;
        s3_idx_reg   <= s2_idx_reg;
        s3_bank_reg  <= s2_ctrl_reg.wr_bank;
        s3_delta_reg <= s3_delta_next;
        win_reg      <= win_next;
    end

endmodule

/* hw/rtl/dsw_seq.sv */
// Query sequencer: input and output handshakes, row and position counters, read issue.
module dsw_seq
    import dsw_pkg::*;
#(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_DICE   = 64,
    parameter int MAX_FACES  = 64,
    parameter int COUNT_BITS = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [DICE_COUNT_W-1:0]         dice_count,
    input  logic [FACE_COUNT_W-1:0]         face_count,
    input  logic [TARGET_SUM_W-1:0]         target_sum,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [COUNT_BITS-1:0]           way_value,
    output logic                            overflowed,
    output dsw_ctrl_t                       ctrl,
    output logic [$clog2(MAX_TARGET+1)-1:0] issue_idx,
    output logic [$clog2(MAX_TARGET+1)-1:0] rd_addr_a,
    output logic [$clog2(MAX_TARGET+1)-1:0] rd_addr_b,
    input  logic [COUNT_BITS-1:0]           result_value,
    input  logic                            sat_seen
);

    localparam int ADDR_W = $clog2(MAX_TARGET + 1);
    localparam int DICE_W = $clog2(MAX_DICE + 1);
    localparam int FACE_W = $clog2(MAX_FACES + 1);

    dsw_state_t            state_reg;
    dsw_state_t            state_next;
    logic [DICE_W-1:0]     dice_reg;
    logic [DICE_W-1:0]     dice_next;
    logic [FACE_W-1:0]     faces_reg;
    logic [FACE_W-1:0]     faces_next;
    logic [ADDR_W-1:0]     target_reg;
    logic [ADDR_W-1:0]     target_next;
    logic                  bad_reg;
    logic                  bad_next;
    logic [DICE_W-1:0]     row_reg;
    logic [DICE_W-1:0]     row_next;
    logic [ADDR_W-1:0]     pos_reg;
    logic [ADDR_W-1:0]     pos_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COUNT_BITS-1:0] way_reg;
    logic [COUNT_BITS-1:0] way_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  in_fire;
    logic                  bad_in;
    logic [DICE_W-1:0]     dice_clamp;
    logic [FACE_W-1:0]     faces_clamp;
    logic                  pos_last;
    logic                  row_last;
    logic                  out_free;

    // Clamping of the incoming transaction.
    always_comb
    begin
        bad_in      = (target_sum > MAX_TARGET);
        dice_clamp  = (dice_count > MAX_DICE) ? DICE_W'(MAX_DICE) : DICE_W'(dice_count);
        faces_clamp = (face_count > MAX_FACES) ? FACE_W'(MAX_FACES) : FACE_W'(face_count);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign pos_last = (pos_reg == target_reg);
    assign row_last = ((row_reg + 1'b1) == dice_reg);
    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (bad_in || (dice_clamp == '0))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                if (pos_last && row_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read issue towards the row stores and the window datapath.
    always_comb
    begin
        ctrl       = '0;
        ctrl.clear = in_fire;
        issue_idx  = pos_reg;
        rd_addr_a  = ADDR_W'(pos_reg - 1'b1);
        rd_addr_b  = ADDR_W'(pos_reg - faces_reg - 1'b1);
        unique case (state_reg)
            ST_ROW:
            begin
                ctrl.valid     = 1'b1;
                ctrl.first_row = (row_reg == '0);
                ctrl.sub_valid = (pos_reg > faces_reg);
                ctrl.init_a    = (pos_reg == ADDR_W'(1));
                ctrl.init_b    = ((pos_reg - 1'b1) == faces_reg);
                ctrl.wr_bank   = row_reg[0];
                ctrl.rd_bank   = ~row_reg[0];
            end
            ST_FETCH:
            begin
                ctrl.valid     = 1'b1;
                ctrl.fetch     = 1'b1;
                ctrl.first_row = bad_reg || (dice_reg == '0);
                ctrl.init_a    = (target_reg == '0);
                ctrl.rd_bank   = ~dice_reg[0];
                issue_idx      = target_reg;
                rd_addr_a      = target_reg;
            end
            ST_IDLE, ST_DRAIN, ST_HOLD, ST_RESULT:
            begin
                ctrl.valid = 1'b0;
            end
            default:
            begin
                ctrl.valid = 1'b0;
            end
        endcase
    end

    // Counters, query fields and the result register.
    always_comb
    begin
        dice_next      = dice_reg;
        faces_next     = faces_reg;
        target_next    = target_reg;
        bad_next       = bad_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        way_next       = way_reg;
        ovf_next       = ovf_reg;
        if (in_fire)
        begin
            dice_next   = dice_clamp;
            faces_next  = faces_clamp;
            target_next = ADDR_W'(target_sum);
            bad_next    = bad_in;
            row_next    = '0;
            pos_next    = '0;
        end
        if (state_reg == ST_ROW)
        begin
            if (pos_last)
            begin
                pos_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        if (state_reg == ST_RESULT)
        begin
            out_valid_next = 1'b1;
            way_next       = bad_reg ? '0 : result_value;
            ovf_next       = bad_reg || sat_seen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign way_value  = way_reg;
    assign overflowed = ovf_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_reg       <= row_next;
            pos_reg       <= pos_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dice_reg   <= dice_next;
        faces_reg  <= faces_next;
        target_reg <= target_next;
        bad_reg    <= bad_next;
        way_reg    <= way_next;
        ovf_reg    <= ovf_next;
    end

endmodule

/* hw/rtl/dice_sum_way_counter.sv */
// Top level of the dice sum way counter.
//
// Each input transaction is one query (dice_count, face_count, target_sum) and gives one
// output transaction: the number of ordered rolls with faces 1 to face_count that add up
// to target_sum, saturated at the all-ones value of COUNT_BITS, with overflowed set when
// any count of the query saturated. A target above MAX_TARGET gives way_count 0 with
// overflowed set. Dice and faces above MAX_DICE and MAX_FACES are clamped. The rows are
// kept in two memories used in turn; each row is one pass over the entries 0 to
// target_sum, one entry per cycle, with an exact running window sum. A query raises its
// result after its last row, if any, has been written and the answer fetched, and
// in_ready rises together with the result. The time is set by the one entry written per
// cycle into the row store, plus the wait while the previous result still sits on the
// output when the new one is ready. A new query is taken while the previous result still
// waits on the output.
module dice_sum_way_counter
    import dsw_pkg::*;
#(
    parameter int MAX_TARGET = 1024,
    parameter int MAX_DICE   = 64,
    parameter int MAX_FACES  = 64,
    parameter int COUNT_BITS = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [DICE_COUNT_W-1:0] dice_count,
    input  logic [FACE_COUNT_W-1:0] face_count,
    input  logic [TARGET_SUM_W-1:0] target_sum,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [WAY_COUNT_W-1:0]  way_count,
    output logic                    overflowed
);

    localparam int ADDR_W = $clog2(MAX_TARGET + 1);

    dsw_ctrl_t             ctrl;
    logic [ADDR_W-1:0]     issue_idx;
    logic [ADDR_W-1:0]     rd_addr_a;
    logic [ADDR_W-1:0]     rd_addr_b;
    logic [COUNT_BITS-1:0] rd0_a;
    logic [COUNT_BITS-1:0] rd0_b;
    logic [COUNT_BITS-1:0] rd1_a;
    logic [COUNT_BITS-1:0] rd1_b;
    logic                  we0;
    logic                  we1;
    logic [ADDR_W-1:0]     waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [COUNT_BITS-1:0] result_value;
    logic                  sat_seen;
    logic [COUNT_BITS-1:0] way_value;

    // Sequencer and result register.
    dsw_seq #(
        .MAX_TARGET (MAX_TARGET),
        .MAX_DICE   (MAX_DICE),
        .MAX_FACES  (MAX_FACES),
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .dice_count   (dice_count),
        .face_count   (face_count),
        .target_sum   (target_sum),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .way_value    (way_value),
        .overflowed   (overflowed),
        .ctrl         (ctrl),
        .issue_idx    (issue_idx),
        .rd_addr_a    (rd_addr_a),
        .rd_addr_b    (rd_addr_b),
        .result_value (result_value),
        .sat_seen     (sat_seen)
    );

    // Window sum datapath.
    dsw_window #(
        .MAX_TARGET (MAX_TARGET),
        .MAX_FACES  (MAX_FACES),
        .COUNT_BITS (COUNT_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .issue_idx    (issue_idx),
        .rd0_a        (rd0_a),
        .rd0_b        (rd0_b),
        .rd1_a        (rd1_a),
        .rd1_b        (rd1_b),
        .we0          (we0),
        .we1          (we1),
        .waddr        (waddr),
        .wdata        (wdata),
        .result_value (result_value),
        .sat_seen     (sat_seen)
    );

    // Row store for even rows.
    dsw_row_mem #(
        .DEPTH  (MAX_TARGET + 1),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_row_mem0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    // Row store for odd rows.
    dsw_row_mem #(
        .DEPTH  (MAX_TARGET + 1),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_row_mem1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    assign way_count = WAY_COUNT_W'(way_value);

endmodule

/* tb/dice_sum_way_counter_tb.sv */
// Self-checking testbench of the dice sum way counter, with its own roll count predictor.
`timescale 1ns / 100ps

module dice_sum_way_counter_tb;
    import dsw_pkg::*;

    localparam int MAX_TARGET  = 1024;
    localparam int MAX_DICE    = 64;
    localparam int MAX_FACES   = 64;
    localparam int COUNT_BITS  = 64;
    localparam int STALL_LIMIT = 300000;
    localparam bit [WAY_COUNT_W:0] SAT_SUM = {1'b0, {WAY_COUNT_W{1'b1}}};

    // One query with the result predicted for it.
    typedef struct {
        bit [DICE_COUNT_W-1:0] dice;
        bit [FACE_COUNT_W-1:0] faces;
        bit [TARGET_SUM_W-1:0] target;
        bit [WAY_COUNT_W-1:0]  ways;
        bit                    ovf;
    } roll_query_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [DICE_COUNT_W-1:0] dice_count = '0;
    logic [FACE_COUNT_W-1:0] face_count = '0;
    logic [TARGET_SUM_W-1:0] target_sum = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [WAY_COUNT_W-1:0]  way_count;
    logic                    overflowed;

    // Rows of the predictor, indexed by partial sum.
    bit [WAY_COUNT_W-1:0] prev_ways [0:MAX_TARGET];
    bit [WAY_COUNT_W-1:0] next_ways [0:MAX_TARGET];

    roll_query_t pending_ways[$];
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          error_count = 0;
    int          stall_cycles = 0;
    int          queries_taken = 0;
    int          results_checked = 0;
    int          beyond_store = 0;
    int          saturated_seen = 0;

    dice_sum_way_counter #(
        .MAX_TARGET (MAX_TARGET),
        .MAX_DICE   (MAX_DICE),
        .MAX_FACES  (MAX_FACES),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .dice_count (dice_count),
        .face_count (face_count),
        .target_sum (target_sum),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .way_count  (way_count),
        .overflowed (overflowed)
    );

    always #6 clk = ~clk;

    // Counts ordered rolls row by row, each entry summing the window of faces below it.
    function automatic roll_query_t count_rolls(input bit [DICE_COUNT_W-1:0] dice,
                                                input bit [FACE_COUNT_W-1:0] faces,
                                                input bit [TARGET_SUM_W-1:0] target);
        roll_query_t          q;
        int                   n_dice;
        int                   n_faces;
        int                   n_target;
        int                   row;
        int                   j;
        int                   m;
        bit [WAY_COUNT_W:0]   acc;

        q.dice   = dice;
        q.faces  = faces;
        q.target = target;
        q.ways   = '0;
        q.ovf    = 1'b0;
        if (target > MAX_TARGET)
        begin
            q.ovf = 1'b1;
            return q;
        end
        n_dice   = (int'(dice) > MAX_DICE) ? MAX_DICE : int'(dice);
        n_faces  = (int'(faces) > MAX_FACES) ? MAX_FACES : int'(faces);
        n_target = int'(target);
        for (j = 0; j <= n_target; j++)
            prev_ways[j] = WAY_COUNT_W'(j == 0);
        for (row = 0; row < n_dice; row++)
        begin
            next_ways[0] = '0;
            for (j = 1; j <= n_target; j++)
            begin
                acc = '0;
                for (m = 1; m <= n_faces && m <= j; m++)
                begin
                    acc = acc + prev_ways[j - m];
                    // Once the sum saturates, further terms cannot change it.
                    if (acc >= SAT_SUM)
                    begin
                        acc = SAT_SUM;
                        break;
                    end
                end
                if (acc == SAT_SUM)
                    q.ovf = 1'b1;
                next_ways[j] = acc[WAY_COUNT_W-1:0];
            end
            for (j = 0; j <= n_target; j++)
                prev_ways[j] = next_ways[j];
        end
        q.ways = prev_ways[n_target];
        return q;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // The receiver stalls at random at the current rate.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Result checking, prediction of each accepted query, and the stall watchdog.
    always @(posedge clk)
    begin
        roll_query_t q;
        if (out_valid && out_ready)
        begin
            results_checked++;
            if (pending_ways.size() == 0)
                report_mismatch($sformatf("result ways %0d ovf %0d with no query waiting",
                                          way_count, overflowed));
            else
            begin
                q = pending_ways.pop_front();
                if (way_count !== q.ways)
                    report_mismatch($sformatf("dice %0d faces %0d target %0d: ways %0d, want %0d",
                                              q.dice, q.faces, q.target, way_count, q.ways));
                if (overflowed !== q.ovf)
                    report_mismatch($sformatf("dice %0d faces %0d target %0d: ovf %0b, want %0b",
                                              q.dice, q.faces, q.target, overflowed, q.ovf));
            end
        end
        if (in_valid && in_ready)
        begin
            q = count_rolls(dice_count, face_count, target_sum);
            pending_ways.push_back(q);
            queries_taken++;
            if (target_sum > MAX_TARGET)
                beyond_store++;
            else if (q.ovf)
                saturated_seen++;
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sends one query, idling first at the current sender rate.
    task automatic send_query(input int dice, input int faces, input int target);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        dice_count <= dice[DICE_COUNT_W-1:0];
        face_count <= faces[FACE_COUNT_W-1:0];
        target_sum <= target[TARGET_SUM_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Holds the sender back until every outstanding result has arrived.
    task automatic wait_for_results;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_ways.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Small queries whose answers are easy to see by hand.
    task automatic test_small_rolls;
        send_query(1, 6, 1);
        send_query(1, 6, 6);
        send_query(1, 6, 7);
        send_query(2, 6, 7);
        send_query(3, 6, 10);
        send_query(5, 1, 5);
        send_query(2, 64, 128);
    endtask

    // Zero dice, zero faces, clamping of dice and faces, and targets beyond the store.
    task automatic test_boundary_cases;
        send_query(0, 6, 0);
        send_query(0, 6, 5);
        send_query(0, 0, 0);
        send_query(3, 0, 3);
        send_query(127, 1, 64);
        send_query(100, 2, 64);
        send_query(1, 127, 64);
        send_query(1, 127, 65);
        send_query(1, 64, 1024);
        send_query(3, 6, 1025);
        send_query(0, 1, 1025);
        send_query(127, 127, 2047);
    endtask

    // A query large enough that counts saturate at all ones.
    task automatic test_saturation;
        send_query(16, 64, 520);
    endtask

    // The largest query: every die, every face, the whole store.
    task automatic test_largest_query;
        send_query(64, 64, 1024);
    endtask

    // Random queries, mostly cheap ones, with a few large and some beyond the store.
    task automatic test_random_queries(input int n);
        int i;
        int pick;
        int d;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_query($urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(0, 48));
            else if (pick < 70)
                send_query($urandom_range(0, 6), $urandom_range(0, 127),
                           $urandom_range(0, 600));
            else if (pick < 85)
                send_query($urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(MAX_TARGET + 1, 2047));
            else if (pick < 97)
            begin
                d = $urandom_range(1, 10);
                pick = $urandom_range(1, 20);
                send_query(d, pick, $urandom_range(d, d * pick));
            end
            else
                send_query($urandom_range(32, 64), $urandom_range(32, 64),
                           $urandom_range(512, MAX_TARGET));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Sender rarely idles, receiver mostly stalls.
        tx_idle_pct = 13;
        rx_idle_pct = 77;
        test_small_rolls;
        test_boundary_cases;
        test_saturation;
        test_largest_query;
        test_random_queries(35);
        wait_for_results;

        // Sender mostly idles, receiver rarely stalls.
        tx_idle_pct = 77;
        rx_idle_pct = 13;
        test_random_queries(35);
        wait_for_results;

        // Back-to-back traffic on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_queries(30);

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_ways.size() != 0);
        repeat (20) @(posedge clk);

        $display("Ran %0d queries and checked %0d results over three idling mixes.",
                 queries_taken, results_checked);
        $display("%0d targets were beyond the row store and %0d queries saturated.",
                 beyond_store, saturated_seen);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* dice_sum_way_counter.f */
hw/rtl/dsw_pkg.sv
hw/rtl/dsw_row_mem.sv
hw/rtl/dsw_window.sv
hw/rtl/dsw_seq.sv
hw/rtl/dice_sum_way_counter.sv
tb/dice_sum_way_counter_tb.sv
